FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk, held off by rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BEC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/bec_pkg.sv
// ---------------------------------------------------------------------------
// bec_pkg
// shared constants for the bin edge congestion grid
// ---------------------------------------------------------------------------
package bec_pkg;

  // field widths
  localparam int unsigned BIN_W      = 16;
  localparam int unsigned GRID_W     = 7;
  localparam int unsigned DIE_W      = 15;
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned DEMAND_W   = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // parameter defaults
  localparam int unsigned DEF_MAX_ROWS   = 64;
  localparam int unsigned DEF_MAX_COLS   = 64;
  localparam int unsigned DEF_COORD_BITS = 16;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  // opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIE_HEIGHT = 3'd5;

  // register reset values
  localparam logic [BIN_W-1:0]  RST_BIN_WIDTH  = 16'd16;
  localparam logic [BIN_W-1:0]  RST_BIN_HEIGHT = 16'd16;
  localparam logic [GRID_W-1:0] RST_GRID_ROWS  = 7'd64;
  localparam logic [GRID_W-1:0] RST_GRID_COLS  = 7'd64;
  localparam logic [DIE_W-1:0]  RST_DIE_WIDTH  = 15'd1024;
  localparam logic [DIE_W-1:0]  RST_DIE_HEIGHT = 15'd1024;

endpackage

FILE: hw/rtl/bec_ram.sv
// ---------------------------------------------------------------------------
// bec_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module bec_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4160
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bec_div.sv
// ---------------------------------------------------------------------------
// bec_div
// restoring divider, one quotient bit per cycle, flags a nonzero remainder
// ---------------------------------------------------------------------------
module bec_div #(
  parameter int unsigned N = 17,
  parameter int unsigned M = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quot,
  output logic         rem_nz
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [M:0]       rem_r;
  logic [N-1:0]     quo_r;
  logic [M-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [M:0]       rem_sh;
  logic             fits;

  // one shift-subtract step
  assign rem_sh = {rem_r[M-1:0], quo_r[N-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (run_r) begin
        rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
        quo_r <= {quo_r[N-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(N - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign quot   = quo_r;
  assign rem_nz = |rem_r;

endmodule

FILE: hw/rtl/bin_edge_congestion_grid_unit.sv
// ---------------------------------------------------------------------------
// bin_edge_congestion_grid_unit
// routing demand on bin grid edges: clear, accumulate a pin pair, read a cell
// ---------------------------------------------------------------------------
// channel  | ports                                      | handshake
// request  | in_opcode, in_first_*, in_second_*, in_cell_* | start high, busy low
// result   | out_cell_average                           | out_valid, one cycle
// config   | cfg_index, cfg_data                        | cfg_we, no wait
//
// after reset the demand memories are swept to zero, one word a cycle over
// (MAX_ROWS+1)*MAX_COLS or (MAX_COLS+1)*MAX_ROWS words, whichever is larger
// clear takes the same sweep; read runs two multiply, two read and a capture
// state (first only if off grid); accumulate runs eight divisions on the shared
// divider, then a read and a write state per edge touched (single port
// read-modify-write), a range state per direction, a base state per non-empty
// direction; busy stays high for the whole request; results cannot be held off
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bin_edge_congestion_grid_unit #(
  parameter int unsigned MAX_ROWS   = bec_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS   = bec_pkg::DEF_MAX_COLS,
  parameter int unsigned COORD_BITS = bec_pkg::DEF_COORD_BITS,
  parameter int unsigned FRAC_BITS  = bec_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bec_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [COORD_BITS-1:0]      in_first_x,
  input  logic signed [COORD_BITS-1:0]      in_first_y,
  input  logic signed [COORD_BITS-1:0]      in_second_x,
  input  logic signed [COORD_BITS-1:0]      in_second_y,
  input  logic [bec_pkg::CELL_W-1:0]        in_cell_row,
  input  logic [bec_pkg::CELL_W-1:0]        in_cell_col,
  output logic                              out_valid,
  output logic [bec_pkg::DEMAND_W-1:0]      out_cell_average,
  input  logic                              cfg_we,
  input  logic [bec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bec_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned CB        = COORD_BITS;
  localparam int unsigned N         = ((CB > FRAC_BITS) ? CB : FRAC_BITS) + 1;
  localparam int unsigned M         = (N > bec_pkg::BIN_W) ? N : bec_pkg::BIN_W;
  localparam int unsigned MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned IDX_W     = $clog2(MAX_DIM + 1);
  localparam int unsigned H_DEPTH   = (MAX_ROWS + 1) * MAX_COLS;
  localparam int unsigned V_DEPTH   = (MAX_COLS + 1) * MAX_ROWS;
  localparam int unsigned CLR_DEPTH = (H_DEPTH > V_DEPTH) ? H_DEPTH : V_DEPTH;
  localparam int unsigned AW        = $clog2(CLR_DEPTH);
  localparam int unsigned HAW       = $clog2(H_DEPTH);
  localparam int unsigned VAW       = $clog2(V_DEPTH);
  localparam int unsigned DW        = bec_pkg::DEMAND_W;
  localparam logic [N-1:0] ONE_Q    = N'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_RANGE, S_BASE, S_EDGE_RD, S_EDGE_WR,
    S_CELL_MUL1, S_CELL_MUL2, S_CELL_RD1, S_CELL_RD2, S_CELL_CAP
  } state_t;

  state_t state_r;

  // configuration
  logic [bec_pkg::BIN_W-1:0]  bin_width_r, bin_height_r;
  logic [bec_pkg::GRID_W-1:0] grid_rows_r, grid_cols_r;
  logic [bec_pkg::DIE_W-1:0]  die_width_r, die_height_r;

  // request state
  logic [N-1:0]              dx_r, dy_r, xlo_r, xhi_r, ylo_r, yhi_r;
  logic                      xneg_r, yneg_r;
  logic [bec_pkg::CELL_W-1:0] cell_r_r, cell_c_r;
  logic [2:0]                div_k_r;
  logic [N-1:0]              spanx_r, spany_r;
  logic [DW-1:0]             hd_r, vd_r;
  logic [N-1:0]              xl_q_r, xh_q_r, yl_q_r, yh_q_r;
  logic                      xl_nz_r, xh_nz_r, yl_nz_r, yh_nz_r;
  logic                      ph_r;
  logic [IDX_W-1:0]          i_r, j_r, jlo_r, jend_r, ihi_r;
  logic [AW-1:0]             base_r, vbase_r, clr_r;
  logic [DW+1:0]             sum_r;
  logic                      out_valid_r;
  logic [DW-1:0]             out_avg_r;

  // effective config
  logic [bec_pkg::BIN_W-1:0] bw_eff, bh_eff;
  logic [IDX_W-1:0]          rows_eff, cols_eff;

  assign bw_eff = (bin_width_r == '0) ? bec_pkg::BIN_W'(1) : bin_width_r;
  assign bh_eff = (bin_height_r == '0) ? bec_pkg::BIN_W'(1) : bin_height_r;
  assign rows_eff = (grid_rows_r == '0) ? IDX_W'(1) :
                    (32'(grid_rows_r) > MAX_ROWS) ? IDX_W'(MAX_ROWS) : IDX_W'(grid_rows_r);
  assign cols_eff = (grid_cols_r == '0) ? IDX_W'(1) :
                    (32'(grid_cols_r) > MAX_COLS) ? IDX_W'(MAX_COLS) : IDX_W'(grid_cols_r);

  // bounding box of the incoming pair
  logic signed [CB-1:0] mnx, mxx, mny, mxy;
  logic [CB:0]          dxw, dyw;
  logic [N-1:0]         xlo_c, xhi_c, ylo_c, yhi_c;

  assign mnx = (in_first_x < in_second_x) ? in_first_x : in_second_x;
  assign mxx = (in_first_x < in_second_x) ? in_second_x : in_first_x;
  assign mny = (in_first_y < in_second_y) ? in_first_y : in_second_y;
  assign mxy = (in_first_y < in_second_y) ? in_second_y : in_first_y;
  assign dxw = {mxx[CB-1], mxx} - {mnx[CB-1], mnx};
  assign dyw = {mxy[CB-1], mxy} - {mny[CB-1], mny};
  assign xlo_c = mnx[CB-1] ? '0 : N'(unsigned'(mnx));
  assign ylo_c = mny[CB-1] ? '0 : N'(unsigned'(mny));
  assign xhi_c = mxx[CB-1] ? '0 :
                 (33'(unsigned'(mxx)) > 33'(die_width_r)) ? N'(die_width_r) :
                 N'(unsigned'(mxx));
  assign yhi_c = mxy[CB-1] ? '0 :
                 (33'(unsigned'(mxy)) > 33'(die_height_r)) ? N'(die_height_r) :
                 N'(unsigned'(mxy));

  // shared divider
  logic         div_start, div_done, div_nz;
  logic [N-1:0] div_a, div_q;
  logic [M-1:0] div_b;

  always_comb begin
    case (div_k_r)
      3'd0:    begin div_a = dx_r;  div_b = M'(bw_eff);  end
      3'd1:    begin div_a = dy_r;  div_b = M'(bh_eff);  end
      3'd2:    begin div_a = ONE_Q; div_b = M'(spanx_r); end
      3'd3:    begin div_a = ONE_Q; div_b = M'(spany_r); end
      3'd4:    begin div_a = xlo_r; div_b = M'(bw_eff);  end
      3'd5:    begin div_a = xhi_r; div_b = M'(bw_eff);  end
      3'd6:    begin div_a = ylo_r; div_b = M'(bh_eff);  end
      default: begin div_a = yhi_r; div_b = M'(bh_eff);  end
    endcase
  end

  assign div_start = (state_r == S_DIV_GO);

  bec_div #(.N(N), .M(M)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem_nz   (div_nz)
  );

  // span from a ceiling quotient, at least one
  logic [N:0] span_c;
  assign span_c = {1'b0, div_q} + (N+1)'(div_nz);

  // edge index ranges for both directions
  logic [N:0] h_ilo, h_ihi, h_jlo, h_jend, v_ilo, v_ihi, v_jlo, v_jend;
  logic [N:0] r_ext, c_ext, xh_c, yh_c;
  logic       h_empty, v_empty;
  logic [N:0] lp_ilo, lp_ihi, lp_jlo, lp_jend;
  logic       lp_empty;

  assign r_ext  = (N+1)'(rows_eff);
  assign c_ext  = (N+1)'(cols_eff);
  assign xh_c   = {1'b0, xh_q_r} + (N+1)'(xh_nz_r);
  assign yh_c   = {1'b0, yh_q_r} + (N+1)'(yh_nz_r);
  assign h_ilo  = {1'b0, yl_q_r} + (N+1)'(yl_nz_r);
  assign h_ihi  = ({1'b0, yh_q_r} > r_ext) ? r_ext : {1'b0, yh_q_r};
  assign h_jlo  = {1'b0, xl_q_r};
  assign h_jend = (xh_c > c_ext) ? c_ext : xh_c;
  assign v_ilo  = {1'b0, xl_q_r} + (N+1)'(xl_nz_r);
  assign v_ihi  = ({1'b0, xh_q_r} > c_ext) ? c_ext : {1'b0, xh_q_r};
  assign v_jlo  = {1'b0, yl_q_r};
  assign v_jend = (yh_c > r_ext) ? r_ext : yh_c;
  assign h_empty = xneg_r || yneg_r || (h_ilo > h_ihi) || (h_jlo >= h_jend);
  assign v_empty = xneg_r || yneg_r || (v_ilo > v_ihi) || (v_jlo >= v_jend);
  assign lp_ilo   = ph_r ? v_ilo   : h_ilo;
  assign lp_ihi   = ph_r ? v_ihi   : h_ihi;
  assign lp_jlo   = ph_r ? v_jlo   : h_jlo;
  assign lp_jend  = ph_r ? v_jend  : h_jend;
  assign lp_empty = ph_r ? v_empty : h_empty;

  // shared multiplier for row bases
  logic [IDX_W-1:0]   stride, mul_a, mul_b;
  logic [2*IDX_W-1:0] prod;

  assign stride = ph_r ? rows_eff : cols_eff;
  always_comb begin
    case (state_r)
      S_CELL_MUL1: begin mul_a = IDX_W'(cell_r_r); mul_b = cols_eff; end
      S_CELL_MUL2: begin mul_a = IDX_W'(cell_c_r); mul_b = rows_eff; end
      default:     begin mul_a = i_r;              mul_b = stride;   end
    endcase
  end
  assign prod = mul_a * mul_b;

  // memory ports
  logic          h_we, v_we;
  logic [AW-1:0] h_addr, v_addr, edge_addr;
  logic [DW-1:0] h_rd, v_rd, h_wd, v_wd, e_rd, delta, sat_wd;
  logic [DW:0]   sat_sum;

  assign edge_addr = base_r + AW'(j_r);
  always_comb begin
    case (state_r)
      S_CLR:      begin h_addr = clr_r; v_addr = clr_r; end
      S_CELL_RD1: begin
        h_addr = base_r + AW'(cell_c_r);
        v_addr = vbase_r + AW'(cell_r_r);
      end
      S_CELL_RD2: begin
        h_addr = base_r + AW'(cols_eff) + AW'(cell_c_r);
        v_addr = vbase_r + AW'(rows_eff) + AW'(cell_r_r);
      end
      default:    begin h_addr = edge_addr; v_addr = edge_addr; end
    endcase
  end

  // saturating edge add
  assign e_rd    = ph_r ? v_rd : h_rd;
  assign delta   = ph_r ? vd_r : hd_r;
  assign sat_sum = {1'b0, e_rd} + {1'b0, delta};
  assign sat_wd  = sat_sum[DW] ? '1 : sat_sum[DW-1:0];

  assign h_we = ((state_r == S_CLR) && (32'(clr_r) < H_DEPTH)) ||
                ((state_r == S_EDGE_WR) && !ph_r);
  assign v_we = ((state_r == S_CLR) && (32'(clr_r) < V_DEPTH)) ||
                ((state_r == S_EDGE_WR) && ph_r);
  assign h_wd = (state_r == S_CLR) ? '0 : sat_wd;
  assign v_wd = (state_r == S_CLR) ? '0 : sat_wd;

  bec_ram #(.WIDTH(DW), .DEPTH(H_DEPTH)) u_hram (
    .clk   (clk),
    .we    (h_we),
    .addr  (h_addr[HAW-1:0]),
    .wdata (h_wd),
    .rdata (h_rd)
  );

  bec_ram #(.WIDTH(DW), .DEPTH(V_DEPTH)) u_vram (
    .clk   (clk),
    .we    (v_we),
    .addr  (v_addr[VAW-1:0]),
    .wdata (v_wd),
    .rdata (v_rd)
  );

  // cell sum of the second pair of edges
  logic [DW+1:0] cell_total;
  assign cell_total = sum_r + (DW+2)'(h_rd) + (DW+2)'(v_rd);

  // sequencer, configuration and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      ph_r         <= 1'b0;
      div_k_r      <= '0;
      bin_width_r  <= bec_pkg::RST_BIN_WIDTH;
      bin_height_r <= bec_pkg::RST_BIN_HEIGHT;
      grid_rows_r  <= bec_pkg::RST_GRID_ROWS;
      grid_cols_r  <= bec_pkg::RST_GRID_COLS;
      die_width_r  <= bec_pkg::RST_DIE_WIDTH;
      die_height_r <= bec_pkg::RST_DIE_HEIGHT;
    end else begin
      out_valid_r <= 1'b0;

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          bec_pkg::REG_BIN_WIDTH:  bin_width_r  <= cfg_data;
          bec_pkg::REG_BIN_HEIGHT: bin_height_r <= cfg_data;
          bec_pkg::REG_GRID_ROWS:  grid_rows_r  <= cfg_data[bec_pkg::GRID_W-1:0];
          bec_pkg::REG_GRID_COLS:  grid_cols_r  <= cfg_data[bec_pkg::GRID_W-1:0];
          bec_pkg::REG_DIE_WIDTH:  die_width_r  <= cfg_data[bec_pkg::DIE_W-1:0];
          bec_pkg::REG_DIE_HEIGHT: die_height_r <= cfg_data[bec_pkg::DIE_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        // zero sweep over both memories
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(CLR_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        // take a request
        S_IDLE: begin
          if (start) begin
            dx_r     <= N'(dxw);
            dy_r     <= N'(dyw);
            xlo_r    <= xlo_c;
            xhi_r    <= xhi_c;
            ylo_r    <= ylo_c;
            yhi_r    <= yhi_c;
            xneg_r   <= mxx[CB-1];
            yneg_r   <= mxy[CB-1];
            cell_r_r <= in_cell_row;
            cell_c_r <= in_cell_col;
            div_k_r  <= '0;
            ph_r     <= 1'b0;
            clr_r    <= '0;
            case (in_opcode)
              bec_pkg::OP_CLEAR: state_r <= S_CLR;
              bec_pkg::OP_ACCUM: state_r <= S_DIV_GO;
              bec_pkg::OP_READ:  state_r <= S_CELL_MUL1;
              default:           state_r <= S_IDLE;
            endcase
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        // collect quotients in turn
        S_DIV_WAIT: begin
          if (div_done) begin
            case (div_k_r)
              3'd0: spanx_r <= (span_c == '0) ? N'(1) : N'(span_c);
              3'd1: spany_r <= (span_c == '0) ? N'(1) : N'(span_c);
              3'd2: hd_r    <= DW'(div_q);
              3'd3: vd_r    <= DW'(div_q);
              3'd4: begin xl_q_r <= div_q; xl_nz_r <= div_nz; end
              3'd5: begin xh_q_r <= div_q; xh_nz_r <= div_nz; end
              3'd6: begin yl_q_r <= div_q; yl_nz_r <= div_nz; end
              default: begin yh_q_r <= div_q; yh_nz_r <= div_nz; end
            endcase
            div_k_r <= div_k_r + 1'b1;
            state_r <= (div_k_r == 3'd7) ? S_RANGE : S_DIV_GO;
          end
        end
        // set up the walk for one direction
        S_RANGE: begin
          if (lp_empty) begin
            ph_r    <= 1'b1;
            state_r <= ph_r ? S_IDLE : S_RANGE;
          end else begin
            i_r     <= IDX_W'(lp_ilo);
            ihi_r   <= IDX_W'(lp_ihi);
            j_r     <= IDX_W'(lp_jlo);
            jlo_r   <= IDX_W'(lp_jlo);
            jend_r  <= IDX_W'(lp_jend);
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          base_r  <= AW'(prod);
          state_r <= S_EDGE_RD;
        end
        S_EDGE_RD: begin
          state_r <= S_EDGE_WR;
        end
        // step through the box
        S_EDGE_WR: begin
          state_r <= S_EDGE_RD;
          if (j_r + 1'b1 == jend_r) begin
            j_r <= jlo_r;
            if (i_r == ihi_r) begin
              ph_r    <= 1'b1;
              state_r <= ph_r ? S_IDLE : S_RANGE;
            end else begin
              i_r    <= i_r + 1'b1;
              base_r <= base_r + AW'(stride);
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        // cell read
        S_CELL_MUL1: begin
          if ((32'(cell_r_r) >= 32'(rows_eff)) || (32'(cell_c_r) >= 32'(cols_eff))) begin
            out_valid_r <= 1'b1;
            out_avg_r   <= '0;
            state_r     <= S_IDLE;
          end else begin
            base_r  <= AW'(prod);
            state_r <= S_CELL_MUL2;
          end
        end
        S_CELL_MUL2: begin
          vbase_r <= AW'(prod);
          state_r <= S_CELL_RD1;
        end
        S_CELL_RD1: begin
          state_r <= S_CELL_RD2;
        end
        S_CELL_RD2: begin
          sum_r   <= (DW+2)'(h_rd) + (DW+2)'(v_rd);
          state_r <= S_CELL_CAP;
        end
        S_CELL_CAP: begin
          out_valid_r <= 1'b1;
          out_avg_r   <= cell_total[DW+1:2];
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_cell_average = out_avg_r;

  `BEC_ASSERT_NEXT(a_single_result, out_valid, !out_valid)
  `BEC_ASSERT_NEXT(a_accept_busy, start && !busy && (in_opcode != bec_pkg::OP_NOP), busy)
  `BEC_ASSERT_IMPL(a_write_busy, h_we || v_we, busy)

endmodule
